>>> rtl/minimum_window_substring_assert.svh
// Assertion macros shared by the checkers of this block.
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
`ifndef MINIMUM_WINDOW_SUBSTRING_ASSERT_SVH
`define MINIMUM_WINDOW_SUBSTRING_ASSERT_SVH

// Same-cycle implication.
`define MWS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MWS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mws_pkg.sv
`default_nettype none
package mws_pkg;

    // default sizing of the buffers and the alphabet
    localparam int DEF_MAX_TEXT    = 1024;
    localparam int DEF_MAX_PATTERN = 1024;
    localparam int DEF_ALPHABET    = 128;

    // fixed port widths
    localparam int SYM_W     = 7;
    localparam int SYM_COUNT = 128;
    localparam int START_W   = 10;
    localparam int LEN_W     = 11;

    // per-cycle strobes into a memory
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_ram_ctl;

endpackage
`default_nettype wire

>>> rtl/mws_need_ram.sv
`default_nettype none
// Per-code table: pattern mark and needed count, one valid bit per entry.
// An entry that is not valid reads as zero. clr drops all valid bits at once.
module mws_need_ram
    import mws_pkg::*;
#(
    parameter int ALPHABET = DEF_ALPHABET,
    parameter int NEED_W   = 12,
    localparam int ADDR_W  = $clog2(ALPHABET)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ram_ctl          i_ctl,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic              i_wr_pat,
    input  wire logic [NEED_W-1:0] i_wr_need,
    output logic                   o_rd_pat,
    output logic [NEED_W-1:0]      o_rd_need
);

    logic [NEED_W:0]       r_mem [ALPHABET];
    logic [ALPHABET-1:0]   r_valid;
    logic [NEED_W:0]       r_rd_data;
    logic                  r_rd_hit;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= {i_wr_pat, i_wr_need};
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_valid <= '0;
        end else if (i_ctl.wr) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_hit  <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_pat  = r_rd_hit & r_rd_data[NEED_W];
    assign o_rd_need = r_rd_hit ? r_rd_data[NEED_W-1:0] : '0;

endmodule
`default_nettype wire

>>> rtl/mws_text_ram.sv
`default_nettype none
// Text buffer: one write port, one registered read port.
module mws_text_ram
    import mws_pkg::*;
#(
    parameter int DEPTH   = DEF_MAX_TEXT,
    parameter int DATA_W  = 7,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire t_ram_ctl          i_ctl,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0]      o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> rtl/minimum_window_substring.sv
`default_nettype none
// Stored pattern beat: busy while the need table is read, then written back.
// Stored text beat: busy for its need-table update, then for each character dropped from the left edge;
// each drop is a text-buffer read followed by a need-table read-modify-write.
// Dropped beat (text buffer or pattern limit full, pattern after text): stays idle unless it ends the query.
// Final beat: the block then stays busy in S_FIN, with the strobe in the cycle after; the receiver cannot stall.
// Reset and end of query clear the query state at once (per-entry valid bits, no sweep).
module minimum_window_substring
    import mws_pkg::*;
#(
    parameter int MAX_TEXT    = DEF_MAX_TEXT,
    parameter int MAX_PATTERN = DEF_MAX_PATTERN,
    parameter int ALPHABET    = DEF_ALPHABET
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_op,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic               i_is_last,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [START_W-1:0]      o_window_start,
    output logic [LEN_W-1:0]        o_window_length,
    output logic                    o_overflow
);

    localparam int CODE_W = $clog2(ALPHABET);
    localparam int TIDX_W = $clog2(MAX_TEXT);
    localparam int CNT_W  = $clog2(MAX_TEXT + 1);
    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int BLEN_W = $clog2(MAX_TEXT + 2);
    localparam int NEED_W = ((CNT_W > PLEN_W) ? CNT_W : PLEN_W) + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAT   = 6'b000010,
        S_TEXT  = 6'b000100,
        S_LREAD = 6'b001000,
        S_LUPD  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic               r_last, n_last;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [PLEN_W-1:0]  r_plen, n_plen;
    logic [PLEN_W-1:0]  r_matched, n_matched;
    logic [CNT_W-1:0]   r_left, n_left;
    logic [CNT_W-1:0]   r_right, n_right;
    logic [TIDX_W-1:0]  r_best_start, n_best_start;
    logic [BLEN_W-1:0]  r_best_len, n_best_len;
    logic               r_ovf, n_ovf;
    logic               r_valid, n_valid;
    logic               r_found, n_found;
    logic [START_W-1:0] r_wstart, n_wstart;
    logic [LEN_W-1:0]   r_wlen, n_wlen;
    logic               r_ovf_out, n_ovf_out;

    // memory ports
    t_ram_ctl           w_need_ctl, w_text_ctl;
    logic [CODE_W-1:0]  w_need_rd_addr, w_need_wr_addr;
    logic               w_need_wr_pat, w_need_rd_pat;
    logic [NEED_W-1:0]  w_need_wr, w_need_rd;
    logic [TIDX_W-1:0]  w_text_wr_addr, w_text_rd_addr;
    logic [CODE_W-1:0]  w_text_rd;

    // symbol to code reduction, constant table
    logic [CODE_W-1:0]  w_code_lut [SYM_COUNT];
    logic [CODE_W-1:0]  w_in_code;

    for (genvar g = 0; g < SYM_COUNT; g++) begin : g_lut
        assign w_code_lut[g] = CODE_W'(g % ALPHABET);
    end

    assign w_in_code = w_code_lut[i_symbol];

    // working values for one window step
    logic [PLEN_W-1:0]  w_nm;
    logic [CNT_W-1:0]   w_nl;
    logic [BLEN_W-1:0]  w_len;
    logic [CNT_W-1:0]   w_rec_left;
    logic               w_rec;

    mws_need_ram #(
        .ALPHABET (ALPHABET),
        .NEED_W   (NEED_W)
    ) u_need (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_need_ctl),
        .i_rd_addr (w_need_rd_addr),
        .i_wr_addr (w_need_wr_addr),
        .i_wr_pat  (w_need_wr_pat),
        .i_wr_need (w_need_wr),
        .o_rd_pat  (w_need_rd_pat),
        .o_rd_need (w_need_rd)
    );

    mws_text_ram #(
        .DEPTH  (MAX_TEXT),
        .DATA_W (CODE_W)
    ) u_text (
        .i_clk     (i_clk),
        .i_ctl     (w_text_ctl),
        .i_wr_addr (w_text_wr_addr),
        .i_wr_data (w_in_code),
        .i_rd_addr (w_text_rd_addr),
        .o_rd_data (w_text_rd)
    );

    // sequencer
    always_comb begin
        n_state        = r_state;
        n_last         = r_last;
        n_code         = r_code;
        n_plen         = r_plen;
        n_matched      = r_matched;
        n_left         = r_left;
        n_right        = r_right;
        n_best_start   = r_best_start;
        n_best_len     = r_best_len;
        n_ovf          = r_ovf;
        n_valid        = 1'b0;
        n_found        = r_found;
        n_wstart       = r_wstart;
        n_wlen         = r_wlen;
        n_ovf_out      = r_ovf_out;
        w_need_ctl     = '0;
        w_text_ctl     = '0;
        w_need_rd_addr = w_in_code;
        w_need_wr_addr = r_code;
        w_need_wr_pat  = 1'b1;
        w_need_wr      = w_need_rd;
        w_text_wr_addr = r_right[TIDX_W-1:0];
        w_text_rd_addr = r_left[TIDX_W-1:0];
        w_nm           = r_matched;
        w_nl           = r_left;
        w_rec          = 1'b0;
        w_rec_left     = r_left;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_last = i_is_last;
                    n_code = w_in_code;
                    n_state = i_is_last ? S_FIN : S_IDLE;
                    if (!i_op) begin
                        if (r_right != '0) begin
                            // pattern after text: dropped silently
                        end else if (r_plen == PLEN_W'(MAX_PATTERN)) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_need_ctl.rd = 1'b1;
                            n_state = S_PAT;
                        end
                    end else begin
                        if (r_right == CNT_W'(MAX_TEXT)) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_text_ctl.wr = 1'b1;
                            w_need_ctl.rd = 1'b1;
                            n_right = r_right + CNT_W'(1);
                            n_state = S_TEXT;
                        end
                    end
                end
            end

            S_PAT: begin
                w_need_ctl.wr = 1'b1;
                w_need_wr     = w_need_rd + NEED_W'(1);
                n_plen        = r_plen + PLEN_W'(1);
                n_state       = r_last ? S_FIN : S_IDLE;
            end

            S_TEXT: begin
                n_state = r_last ? S_FIN : S_IDLE;
                if (w_need_rd_pat) begin
                    w_need_ctl.wr = 1'b1;
                    w_need_wr     = w_need_rd - NEED_W'(1);
                    // old count positive: this character fills a need
                    if (!w_need_rd[NEED_W-1] && w_need_rd != '0) begin
                        w_nm = r_matched + PLEN_W'(1);
                    end
                    n_matched = w_nm;
                    if (w_nm == r_plen && r_left < r_right) begin
                        w_rec         = 1'b1;
                        w_text_ctl.rd = 1'b1;
                        n_state       = S_LREAD;
                    end
                end
            end

            S_LREAD: begin
                n_code         = w_text_rd;
                w_need_rd_addr = w_text_rd;
                w_need_ctl.rd  = 1'b1;
                n_state        = S_LUPD;
            end

            S_LUPD: begin
                if (w_need_rd_pat) begin
                    w_need_ctl.wr = 1'b1;
                    w_need_wr     = w_need_rd + NEED_W'(1);
                    // old count not negative: a need opens again
                    if (!w_need_rd[NEED_W-1]) begin
                        w_nm = r_matched - PLEN_W'(1);
                    end
                end
                n_matched = w_nm;
                w_nl      = r_left + CNT_W'(1);
                n_left    = w_nl;
                if (w_nm == r_plen && w_nl < r_right) begin
                    w_rec          = 1'b1;
                    w_rec_left     = w_nl;
                    w_text_rd_addr = w_nl[TIDX_W-1:0];
                    w_text_ctl.rd  = 1'b1;
                    n_state        = S_LREAD;
                end else begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end

            S_FIN: begin
                // emit the result and return to the reset state
                n_valid        = 1'b1;
                n_found        = (r_best_len <= BLEN_W'(MAX_TEXT));
                n_wstart       = n_found ? START_W'(r_best_start) : '0;
                n_wlen         = n_found ? LEN_W'(r_best_len) : '0;
                n_ovf_out      = r_ovf;
                w_need_ctl.clr = 1'b1;
                n_plen         = '0;
                n_matched      = '0;
                n_left         = '0;
                n_right        = '0;
                n_best_start   = '0;
                n_best_len     = BLEN_W'(MAX_TEXT + 1);
                n_ovf          = 1'b0;
                n_last         = 1'b0;
                n_state        = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // record a covering window if it beats the best so far
        w_len = BLEN_W'(r_right - w_rec_left);
        if (w_rec && w_len < r_best_len) begin
            n_best_start = w_rec_left[TIDX_W-1:0];
            n_best_len   = w_len;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last       <= 1'b0;
            r_plen       <= '0;
            r_matched    <= '0;
            r_left       <= '0;
            r_right      <= '0;
            r_best_start <= '0;
            r_best_len   <= BLEN_W'(MAX_TEXT + 1);
            r_ovf        <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_last       <= n_last;
            r_plen       <= n_plen;
            r_matched    <= n_matched;
            r_left       <= n_left;
            r_right      <= n_right;
            r_best_start <= n_best_start;
            r_best_len   <= n_best_len;
            r_ovf        <= n_ovf;
            r_valid      <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_found   <= n_found;
        r_wstart  <= n_wstart;
        r_wlen    <= n_wlen;
        r_ovf_out <= n_ovf_out;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_window_start  = r_wstart;
    assign o_window_length = r_wlen;
    assign o_overflow      = r_ovf_out;

endmodule
`default_nettype wire

>>> rtl/mws_checker.sv
`default_nettype none
`include "minimum_window_substring_assert.svh"
// Port-level checks on the result beat.
module mws_checker
    import mws_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               busy,
    input wire logic               o_valid,
    input wire logic               o_found,
    input wire logic [START_W-1:0] o_window_start,
    input wire logic [LEN_W-1:0]   o_window_length
);

    // a result beat lasts one cycle
    `MWS_ASSERT_NXT(a_strobe_single, o_valid, !o_valid, "result strobe held over two cycles")

    // the result comes out of a busy period and leaves the block ready
    `MWS_ASSERT_IMP(a_result_ready, o_valid, !busy && $past(busy), "result not at end of work")

    // no window: start and length read zero
    `MWS_ASSERT_IMP(a_empty_result, o_valid && !o_found,
        o_window_length == '0 && o_window_start == '0, "empty result carries a window")

    // a found window is never empty
    `MWS_ASSERT_IMP(a_found_len, o_valid && o_found, o_window_length != '0,
        "found window of zero length")

endmodule

bind minimum_window_substring mws_checker u_mws_checker (.*);
`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none
module tb_top;
    import mws_pkg::*;

    localparam int MAX_TXT = DEF_MAX_TEXT;
    localparam int MAX_PAT = DEF_MAX_PATTERN;
    localparam int N_RAND  = 400;

    typedef enum logic {
        OP_PAT  = 1'b0,
        OP_TEXT = 1'b1
    } t_op;

    // one input beat
    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] sym;
        logic             last;
    } t_beat;

    // one query result
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] lo;
        logic [LEN_W-1:0]   len;
        logic               ovf;
    } t_window;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               i_op = 1'b0;
    logic [SYM_W-1:0]   i_symbol = '0;
    logic               i_is_last = 1'b0;
    logic               busy;
    logic               o_valid;
    logic               o_found;
    logic [START_W-1:0] o_window_start;
    logic [LEN_W-1:0]   o_window_length;
    logic               o_overflow;

    t_beat   beat_q[$];
    t_window window_q[$];
    int      n_sent = 0;
    int      n_fail = 0;

    // predictor state
    int                 need_ct[SYM_COUNT];
    bit                 in_pat[SYM_COUNT];
    logic [SYM_W-1:0]   text_mem[MAX_TXT];
    logic [LEN_W-1:0]   pat_len;
    logic [LEN_W-1:0]   hit_ct;
    logic [LEN_W-1:0]   lo_idx;
    logic [LEN_W-1:0]   hi_idx;
    logic [START_W-1:0] best_lo;
    logic [LEN_W-1:0]   best_len;
    logic               ovf_seen;

    minimum_window_substring i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_symbol        (i_symbol),
        .i_is_last       (i_is_last),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_window_start  (o_window_start),
        .o_window_length (o_window_length),
        .o_overflow      (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // back to the empty-query state
    function automatic void window_clear();
        for (int k = 0; k < SYM_COUNT; k++) begin
            need_ct[k] = 0;
            in_pat[k]  = 1'b0;
        end
        pat_len  = '0;
        hit_ct   = '0;
        lo_idx   = '0;
        hi_idx   = '0;
        best_lo  = '0;
        best_len = LEN_W'(MAX_TXT + 1);
        ovf_seen = 1'b0;
    endfunction

    // advance the sliding window by one accepted beat
    function automatic void window_track(t_op op, logic [SYM_W-1:0] sym, logic last);
        t_window          res;
        logic [LEN_W-1:0] r;
        logic [SYM_W-1:0] gone;
        if (op == OP_PAT && hi_idx == 0) begin
            if (pat_len >= MAX_PAT) begin
                ovf_seen = 1'b1;
            end else begin
                in_pat[sym] = 1'b1;
                need_ct[sym]++;
                pat_len++;
            end
        end else if (op == OP_TEXT) begin
            if (hi_idx >= MAX_TXT) begin
                ovf_seen = 1'b1;
            end else begin
                r = hi_idx;
                text_mem[r[START_W-1:0]] = sym;
                hi_idx = r + 1'b1;
                if (in_pat[sym]) begin
                    need_ct[sym]--;
                    if (need_ct[sym] >= 0)
                        hit_ct++;
                    // shrink from the left while the whole pattern is covered
                    while (hit_ct == pat_len && lo_idx <= r) begin
                        if (r - lo_idx + 1'b1 < best_len) begin
                            best_lo  = lo_idx[START_W-1:0];
                            best_len = r - lo_idx + 1'b1;
                        end
                        gone = text_mem[lo_idx[START_W-1:0]];
                        if (in_pat[gone]) begin
                            need_ct[gone]++;
                            if (need_ct[gone] > 0)
                                hit_ct--;
                        end
                        lo_idx++;
                    end
                end
            end
        end
        if (last) begin
            res.found = (best_len <= MAX_TXT);
            res.lo    = res.found ? best_lo : '0;
            res.len   = res.found ? best_len : '0;
            res.ovf   = ovf_seen;
            window_q.push_back(res);
            window_clear();
        end
    endfunction

    function automatic bit take_gap();
        if (n_sent >= 200 && n_sent < 800)
            return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    function automatic void push_beat(t_op op, logic [SYM_W-1:0] sym, logic last);
        t_beat b;
        b.op   = op;
        b.sym  = sym;
        b.last = last;
        beat_q.push_back(b);
    endfunction

    function automatic void push_str(t_op op, string s, logic last);
        byte ch;
        for (int k = 0; k < s.len(); k++) begin
            ch = s[k];
            push_beat(op, ch[SYM_W-1:0], last && (k == s.len() - 1));
        end
    endfunction

    // driver: hold a beat until taken, then present the next one or idle
    always @(posedge i_clk) begin : drive_beats
        t_beat nxt;
        if (i_rst_n) begin
            if (start && !busy) begin
                window_track(t_op'(i_op), i_symbol, i_is_last);
                n_sent++;
            end
            if (!(start && busy)) begin
                if (beat_q.size() != 0 && !take_gap()) begin
                    nxt = beat_q.pop_front();
                    start     <= 1'b1;
                    i_op      <= nxt.op;
                    i_symbol  <= nxt.sym;
                    i_is_last <= nxt.last;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [LEN_W-1:0] want,
                                        logic [LEN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_fail++;
        end
    endfunction

    // monitor: every strobed result against the oldest prediction
    always @(posedge i_clk) begin : watch_results
        t_window want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (window_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b/%0d/%0d/%0b",
                         $time, o_found, o_window_start, o_window_length, o_overflow);
                n_fail++;
            end else begin
                want = window_q.pop_front();
                check_field("found", LEN_W'(want.found), LEN_W'(o_found));
                check_field("window_start", LEN_W'(want.lo), LEN_W'(o_window_start));
                check_field("window_length", want.len, o_window_length);
                check_field("overflow", LEN_W'(want.ovf), LEN_W'(o_overflow));
            end
        end
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        int               base;
        int               span;
        int               plen;
        int               tlen;
        int               kind;
        int               n_rand;
        logic [SYM_W-1:0] key;
        window_clear();

        // directed: empty pattern, then empty text with is_last on a pattern char
        push_str(OP_TEXT, "ab", 1'b1);
        push_str(OP_PAT, "x", 1'b1);
        // duplicates in the pattern
        push_str(OP_PAT, "aab", 1'b0);
        push_str(OP_TEXT, "cabaa", 1'b1);
        // symbol extremes
        push_beat(OP_PAT, 7'd0, 1'b0);
        push_beat(OP_PAT, 7'd127, 1'b0);
        push_beat(OP_TEXT, 7'd127, 1'b0);
        push_beat(OP_TEXT, 7'd5, 1'b0);
        push_beat(OP_TEXT, 7'd0, 1'b1);
        // pattern char after text is dropped
        push_str(OP_PAT, "q", 1'b0);
        push_str(OP_TEXT, "q", 1'b0);
        push_str(OP_PAT, "z", 1'b0);
        push_str(OP_TEXT, "zq", 1'b1);
        // pattern never covered
        push_str(OP_PAT, "zz", 1'b0);
        push_str(OP_TEXT, "z", 1'b1);

        // full text plus two: the only cover spans the whole buffer
        key = SYM_W'($urandom_range(0, 127));
        push_beat(OP_PAT, key, 1'b0);
        push_beat(OP_PAT, key + 7'd1, 1'b0);
        push_beat(OP_TEXT, key + 7'd1, 1'b0);
        for (int k = 1; k < MAX_TXT - 1; k++)
            push_beat(OP_TEXT, key + 7'd2 + SYM_W'($urandom_range(0, 125)), 1'b0);
        push_beat(OP_TEXT, key, 1'b0);
        push_beat(OP_TEXT, SYM_W'($urandom_range(0, 127)), 1'b0);
        push_beat(OP_TEXT, SYM_W'($urandom_range(0, 127)), 1'b1);

        // random queries over a narrow alphabet so windows close often
        n_rand = 0;
        while (n_rand < N_RAND) begin
            kind = $urandom_range(0, 99);
            base = $urandom_range(0, 127);
            span = (kind >= 90) ? 127 : $urandom_range(1, 6);
            plen = (kind < 5) ? 0 : $urandom_range(1, 6);
            tlen = $urandom_range(0, 40);
            if (plen == 0 && tlen == 0)
                tlen = 1;
            if (kind >= 10 && kind < 15 && tlen == 0)
                tlen = 1;
            for (int k = 0; k < plen; k++)
                push_beat(OP_PAT, SYM_W'(base + $urandom_range(0, span)),
                          tlen == 0 && k == plen - 1);
            for (int k = 0; k < tlen; k++) begin
                // stray pattern chars inside the text
                if (kind >= 5 && kind < 10 && $urandom_range(0, 3) == 0)
                    push_beat(OP_PAT, SYM_W'(base + $urandom_range(0, span)), 1'b0);
                push_beat(OP_TEXT, SYM_W'(base + $urandom_range(0, span)),
                          k == tlen - 1 && !(kind >= 10 && kind < 15));
            end
            // query closed by a pattern char after the text
            if (kind >= 10 && kind < 15)
                push_beat(OP_PAT, SYM_W'(base + $urandom_range(0, span)), 1'b1);
            n_rand += plen + tlen + 1;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beat_q.size() != 0 || start)
            @(posedge i_clk);
        while (window_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
`default_nettype wire
